/* hw/rtl/tls_pkg.sv */
// Shared types and constants of the template literal scanner.
// Holds character codes, the byte class and result types used by all modules.
// Depends on nothing.
`timescale 1ns / 1ps

package tls_pkg;

	localparam int NEST_DEPTH  = 8;
	localparam int MAX_LENGTH  = 65535;
	localparam int LEN_W       = 16;
	localparam int LEN_CAP     = (MAX_LENGTH < 65535) ? MAX_LENGTH : 65535;
	localparam int BRACE_W     = 10;
	localparam int BRACE_CAP   = 1023;
	localparam int PTR_W       = $clog2(NEST_DEPTH + 1);
	localparam int IDX_W       = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
	localparam int QUEUE_DEPTH = 2;
	localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_BTICK  = 8'h60;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	typedef enum logic [2:0] {
		CLS_OTHER,
		CLS_NUL,
		CLS_BTICK,
		CLS_DOLLAR,
		CLS_LBRACE,
		CLS_RBRACE,
		CLS_BSLASH,
		CLS_SQUOTE
	} cls_t;

	typedef enum logic [1:0] {
		ST_NONE,
		ST_MATCH,
		ST_UNTERM,
		ST_OVER
	} status_t;

	typedef struct packed {
		logic begin_req;
		cls_t cls;
	} item_t;

	typedef struct packed {
		status_t          status;
		logic [LEN_W-1:0] token_length;
		logic             content_begin;
		logic [LEN_W-1:0] content_end;
	} result_t;

endpackage

/* hw/rtl/tls_front.sv */
// Front end of the template literal scanner: sorts each text byte into a class.
// Uses tls_pkg for the character codes and the item type.
`timescale 1ns / 1ps

module tls_front (
	input  logic [7:0]     ch,
	input  logic           begin_req,
	output tls_pkg::item_t item
);

	tls_pkg::cls_t cls;

	always_comb begin
		unique case (ch)
			tls_pkg::CH_NUL:    cls = tls_pkg::CLS_NUL;
			tls_pkg::CH_BTICK:  cls = tls_pkg::CLS_BTICK;
			tls_pkg::CH_DOLLAR: cls = tls_pkg::CLS_DOLLAR;
			tls_pkg::CH_LBRACE: cls = tls_pkg::CLS_LBRACE;
			tls_pkg::CH_RBRACE: cls = tls_pkg::CLS_RBRACE;
			tls_pkg::CH_BSLASH: cls = tls_pkg::CLS_BSLASH;
			tls_pkg::CH_SQUOTE: cls = tls_pkg::CLS_SQUOTE;
			default:            cls = tls_pkg::CLS_OTHER;
		endcase
	end

	assign item.begin_req = begin_req;
	assign item.cls       = cls;

endmodule

/* hw/rtl/tls_queue.sv */
// Short queue of classified bytes between the front and back of the scanner.
// Uses tls_pkg for the item type and the queue depth.
`timescale 1ns / 1ps

module tls_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	input  tls_pkg::item_t push_item,
	output logic           full,
	output logic           pop_valid,
	output tls_pkg::item_t pop_item,
	input  logic           pop
);

	tls_pkg::item_t               mem_q [tls_pkg::QUEUE_DEPTH];
	logic [tls_pkg::QIDX_W-1:0]   wr_q;
	logic [tls_pkg::QIDX_W-1:0]   rd_q;
	logic [tls_pkg::QCNT_W-1:0]   cnt_q;
	logic                         push;

	assign full      = (cnt_q == tls_pkg::QCNT_W'(tls_pkg::QUEUE_DEPTH));
	assign pop_valid = (cnt_q != '0);
	assign pop_item  = mem_q[rd_q];
	assign push      = push_valid && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == tls_pkg::QIDX_W'(tls_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == tls_pkg::QIDX_W'(tls_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_item;
		end
	end

endmodule

/* hw/rtl/tls_back.sv */
// Back end of the template literal scanner: scan state, nesting stack and result register.
// Uses tls_pkg for the byte classes, status codes and the result type.
`timescale 1ns / 1ps

module tls_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  tls_pkg::item_t   item,
	output logic             pop,
	output logic             res_valid,
	output tls_pkg::result_t res,
	input  logic             res_stall
);

	typedef enum logic [2:0] {
		M_IDLE,
		M_TEXT,
		M_TEXT_DOLLAR,
		M_EXPR,
		M_SQUOTE,
		M_BQUOTE,
		M_BQUOTE_DOLLAR
	} mode_t;

	mode_t                         mode_q, mode_d;
	logic                          esc_q, esc_d;
	logic [tls_pkg::LEN_W-1:0]     len_q, len_d, len_n;
	logic [tls_pkg::PTR_W-1:0]     ptr_q, ptr_d, ptr_m1;
	logic [tls_pkg::BRACE_W-1:0]   stack_q [tls_pkg::NEST_DEPTH];
	logic [tls_pkg::IDX_W-1:0]     top_idx;
	logic [tls_pkg::BRACE_W-1:0]   top_cnt;
	logic                          wr_en;
	logic [tls_pkg::IDX_W-1:0]     wr_idx;
	logic [tls_pkg::BRACE_W-1:0]   wr_val;
	logic                          emit, r_match, r_over, do_open;
	logic                          res_valid_q;
	tls_pkg::result_t              res_q, res_d;
	tls_pkg::cls_t                 cls;

	assign cls     = item.cls;
	assign ptr_m1  = ptr_q - 1'b1;
	assign top_idx = ptr_m1[tls_pkg::IDX_W-1:0];
	assign top_cnt = stack_q[top_idx];
	assign len_n   = (len_q < tls_pkg::LEN_W'(tls_pkg::LEN_CAP)) ? len_q + 1'b1 : len_q;
	assign pop     = item_valid && (!res_valid_q || !res_stall);

	always_comb begin
		mode_d  = mode_q;
		esc_d   = esc_q;
		len_d   = len_q;
		ptr_d   = ptr_q;
		wr_en   = 1'b0;
		wr_idx  = top_idx;
		wr_val  = top_cnt;
		emit    = 1'b0;
		r_match = 1'b0;
		r_over  = 1'b0;
		do_open = 1'b0;
		res_d   = '0;
		if (item.begin_req) begin
			esc_d = 1'b0;
			ptr_d = '0;
			if (cls != tls_pkg::CLS_BTICK) begin
				mode_d       = M_IDLE;
				len_d        = '0;
				emit         = 1'b1;
				res_d.status = tls_pkg::ST_NONE;
			end else begin
				mode_d = M_TEXT;
				len_d  = tls_pkg::LEN_W'(1);
			end
		end else if (mode_q != M_IDLE) begin
			if (cls == tls_pkg::CLS_NUL) begin
				emit                = 1'b1;
				res_d.status        = tls_pkg::ST_UNTERM;
				res_d.token_length  = len_q;
				res_d.content_begin = 1'b1;
				res_d.content_end   = len_q;
				mode_d              = M_IDLE;
			end else begin
				len_d = len_n;
				unique case (mode_q)
					M_TEXT, M_TEXT_DOLLAR: begin
						if (mode_q == M_TEXT_DOLLAR && cls == tls_pkg::CLS_LBRACE) begin
							do_open = 1'b1;
						end else begin
							mode_d = M_TEXT;
							if (esc_q && (cls == tls_pkg::CLS_BSLASH ||
								cls == tls_pkg::CLS_BTICK || cls == tls_pkg::CLS_DOLLAR)) begin
								esc_d = 1'b0;
							end else begin
								esc_d = (cls == tls_pkg::CLS_BSLASH);
								if (cls == tls_pkg::CLS_BTICK) begin
									r_match = 1'b1;
								end else if (cls == tls_pkg::CLS_DOLLAR) begin
									mode_d = M_TEXT_DOLLAR;
								end
							end
						end
					end
					M_BQUOTE, M_BQUOTE_DOLLAR: begin
						if (mode_q == M_BQUOTE_DOLLAR && cls == tls_pkg::CLS_LBRACE) begin
							do_open = 1'b1;
						end else begin
							mode_d = M_BQUOTE;
							if (esc_q && (cls == tls_pkg::CLS_BSLASH ||
								cls == tls_pkg::CLS_BTICK || cls == tls_pkg::CLS_DOLLAR)) begin
								esc_d = 1'b0;
							end else begin
								esc_d = (cls == tls_pkg::CLS_BSLASH);
								if (cls == tls_pkg::CLS_BTICK) begin
									mode_d = M_EXPR;
								end else if (cls == tls_pkg::CLS_DOLLAR) begin
									mode_d = M_BQUOTE_DOLLAR;
								end
							end
						end
					end
					M_SQUOTE: begin
						if (esc_q && (cls == tls_pkg::CLS_BSLASH ||
							cls == tls_pkg::CLS_SQUOTE)) begin
							esc_d = 1'b0;
						end else begin
							esc_d = (cls == tls_pkg::CLS_BSLASH);
							if (cls == tls_pkg::CLS_SQUOTE) begin
								mode_d = M_EXPR;
							end
						end
					end
					M_EXPR: begin
						if (ptr_q == '0 || ptr_q > tls_pkg::PTR_W'(tls_pkg::NEST_DEPTH)) begin
							mode_d = M_TEXT;
							ptr_d  = '0;
						end else begin
							esc_d = 1'b0;
							priority case (cls)
								tls_pkg::CLS_SQUOTE: mode_d = M_SQUOTE;
								tls_pkg::CLS_BTICK:  mode_d = M_BQUOTE;
								tls_pkg::CLS_LBRACE: begin
									if (top_cnt >= tls_pkg::BRACE_W'(tls_pkg::BRACE_CAP)) begin
										r_over = 1'b1;
									end else begin
										wr_en  = 1'b1;
										wr_val = top_cnt + 1'b1;
									end
								end
								tls_pkg::CLS_RBRACE: begin
									wr_en  = 1'b1;
									wr_val = top_cnt - 1'b1;
									if (top_cnt == tls_pkg::BRACE_W'(1)) begin
										ptr_d  = ptr_m1;
										mode_d = (ptr_m1 == '0) ? M_TEXT : M_BQUOTE;
									end
								end
								default: ;
							endcase
						end
					end
					default: mode_d = M_IDLE;
				endcase
				if (do_open) begin
					if (ptr_q >= tls_pkg::PTR_W'(tls_pkg::NEST_DEPTH)) begin
						r_over = 1'b1;
					end else begin
						wr_en  = 1'b1;
						wr_idx = ptr_q[tls_pkg::IDX_W-1:0];
						wr_val = tls_pkg::BRACE_W'(1);
						ptr_d  = ptr_q + 1'b1;
						mode_d = M_EXPR;
						esc_d  = 1'b0;
					end
				end
				if (r_match) begin
					emit                = 1'b1;
					res_d.status        = tls_pkg::ST_MATCH;
					res_d.token_length  = len_n;
					res_d.content_begin = 1'b1;
					res_d.content_end   = len_n - 1'b1;
					mode_d              = M_IDLE;
				end
				if (r_over) begin
					emit                = 1'b1;
					res_d.status        = tls_pkg::ST_OVER;
					res_d.token_length  = len_n;
					res_d.content_begin = 1'b1;
					res_d.content_end   = len_n;
					mode_d              = M_IDLE;
					esc_d               = 1'b0;
					ptr_d               = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_IDLE;
			esc_q       <= 1'b0;
			len_q       <= '0;
			ptr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mode_q      <= mode_d;
				esc_q       <= esc_d;
				len_q       <= len_d;
				ptr_q       <= ptr_d;
				res_valid_q <= emit;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && wr_en) begin
			stack_q[wr_idx] <= wr_val;
		end
		if (pop && emit) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* hw/rtl/template_literal_scanner_top.sv */
// Top level of the template literal scanner.
// Instantiates tls_front, tls_queue and tls_back; uses tls_pkg for types.
//
// Text enters one byte per transfer on the text channel (text_valid, text_stall,
// ch, begin_req); a byte with begin_req set starts a token attempt, and byte 0
// ends the text. Each attempt yields at most one result on the result channel
// (result_valid, result_stall, status, token_length, content_begin, content_end).
// A byte that ends an attempt passes through the two-entry queue and then the result
// register before its result shows. The block takes one byte per cycle sustained
// while the receiver does not stall; the scan state and nesting stack are updated
// from each byte as it is popped, so the byte loop sets that rate.
// When the receiver stalls a pending result, the result register holds and the back
// end stops; the queue then fills and text_stall rises at most two transfers later.
// Reset clears the scan state, the queue pointers and the result valid flag; the
// nesting stack needs no clearing since only entries already written are read.
`timescale 1ns / 1ps

module template_literal_scanner_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  ch,
	input  logic        begin_req,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  status,
	output logic [15:0] token_length,
	output logic        content_begin,
	output logic [15:0] content_end
);

	tls_pkg::item_t   front_item;
	tls_pkg::item_t   q_item;
	logic             q_valid;
	logic             q_pop;
	logic             q_full;
	tls_pkg::result_t res;

	tls_front u_front (
		.ch        (ch),
		.begin_req (begin_req),
		.item      (front_item)
	);

	tls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (text_valid),
		.push_item  (front_item),
		.full       (q_full),
		.pop_valid  (q_valid),
		.pop_item   (q_item),
		.pop        (q_pop)
	);

	tls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_valid),
		.item       (q_item),
		.pop        (q_pop),
		.res_valid  (result_valid),
		.res        (res),
		.res_stall  (result_stall)
	);

	assign text_stall    = q_full;
	assign status        = res.status;
	assign token_length  = res.token_length;
	assign content_begin = res.content_begin;
	assign content_end   = res.content_end;

	a_no_match_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == tls_pkg::ST_NONE |->
		token_length == '0 && content_end == '0 && !content_begin)
		else $error("No-match result carries nonzero fields.");

	a_match_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == tls_pkg::ST_MATCH |->
		content_begin && content_end == token_length - 16'd1 && token_length >= 16'd2)
		else $error("Matched result has inconsistent content offsets.");

	a_open_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == tls_pkg::ST_UNTERM || status == tls_pkg::ST_OVER) |->
		content_begin && content_end == token_length && token_length != '0)
		else $error("Unterminated or overflow result has inconsistent offsets.");

endmodule

/* bench/literal_track_pkg.sv */
// Scoreboard for the template literal scanner bench: follows the scan state byte by byte,
// predicts each result and compares it with what the block delivers.
// Depends on tls_pkg for the character codes, status codes, limits and result type.
`timescale 1ns / 1ps

package literal_track_pkg;

	import tls_pkg::*;

	typedef enum logic [2:0] {
		MD_IDLE,
		MD_TEXT,
		MD_TEXT_DOLLAR,
		MD_EXPR,
		MD_SQUOTE,
		MD_BQUOTE,
		MD_BQUOTE_DOLLAR
	} scan_mode_t;

	typedef enum logic [1:0] {
		STEP_GO,
		STEP_MATCH,
		STEP_OVER
	} step_t;

	class literal_tracker;
		scan_mode_t  mode;
		bit          esc;
		int unsigned len;
		int unsigned brace_count [NEST_DEPTH];
		int unsigned depth;
		result_t     expected_results [$];
		int unsigned mismatches;

		function new();
			mode = MD_IDLE;
			esc = 1'b0;
			len = 0;
			depth = 0;
			mismatches = 0;
			foreach (brace_count[i])
				brace_count[i] = 0;
		endfunction

		function void expect_result(status_t st, int unsigned tl, bit cb, int unsigned ce);
			result_t r;
			r.status = st;
			r.token_length = tl[LEN_W-1:0];
			r.content_begin = cb;
			r.content_end = ce[LEN_W-1:0];
			expected_results.push_back(r);
		endfunction

		function step_t text_char(logic [7:0] c);
			if (esc) begin
				esc = 1'b0;
				if (c == CH_BSLASH || c == CH_BTICK || c == CH_DOLLAR)
					return STEP_GO;
			end
			if (c == CH_BSLASH)
				esc = 1'b1;
			else if (c == CH_BTICK)
				return STEP_MATCH;
			else if (c == CH_DOLLAR)
				mode = MD_TEXT_DOLLAR;
			return STEP_GO;
		endfunction

		function void bquote_char(logic [7:0] c);
			if (esc) begin
				esc = 1'b0;
				if (c == CH_BSLASH || c == CH_BTICK || c == CH_DOLLAR)
					return;
			end
			if (c == CH_BSLASH)
				esc = 1'b1;
			else if (c == CH_BTICK)
				mode = MD_EXPR;
			else if (c == CH_DOLLAR)
				mode = MD_BQUOTE_DOLLAR;
		endfunction

		function void squote_char(logic [7:0] c);
			if (esc) begin
				esc = 1'b0;
				if (c == CH_BSLASH || c == CH_SQUOTE)
					return;
			end
			if (c == CH_BSLASH)
				esc = 1'b1;
			else if (c == CH_SQUOTE)
				mode = MD_EXPR;
		endfunction

		function step_t open_expr();
			if (depth >= NEST_DEPTH)
				return STEP_OVER;
			brace_count[depth] = 1;
			depth++;
			mode = MD_EXPR;
			esc = 1'b0;
			return STEP_GO;
		endfunction

		function step_t expr_char(logic [7:0] c);
			int unsigned top;
			if (depth == 0 || depth > NEST_DEPTH) begin
				mode = MD_TEXT;
				depth = 0;
				return STEP_GO;
			end
			top = depth - 1;
			esc = 1'b0;
			if (c == CH_SQUOTE) begin
				mode = MD_SQUOTE;
			end else if (c == CH_BTICK) begin
				mode = MD_BQUOTE;
			end else if (c == CH_LBRACE) begin
				if (brace_count[top] >= BRACE_CAP)
					return STEP_OVER;
				brace_count[top]++;
			end else if (c == CH_RBRACE) begin
				brace_count[top]--;
				if (brace_count[top] == 0) begin
					depth--;
					mode = (depth == 0) ? MD_TEXT : MD_BQUOTE;
				end
			end
			return STEP_GO;
		endfunction

		function step_t advance(logic [7:0] c);
			case (mode)
				MD_TEXT_DOLLAR: begin
					if (c == CH_LBRACE)
						return open_expr();
					mode = MD_TEXT;
					return text_char(c);
				end
				MD_TEXT: return text_char(c);
				MD_EXPR: return expr_char(c);
				MD_SQUOTE: begin
					squote_char(c);
					return STEP_GO;
				end
				MD_BQUOTE_DOLLAR: begin
					if (c == CH_LBRACE)
						return open_expr();
					mode = MD_BQUOTE;
					bquote_char(c);
					return STEP_GO;
				end
				MD_BQUOTE: begin
					bquote_char(c);
					return STEP_GO;
				end
				default: begin
					mode = MD_IDLE;
					return STEP_GO;
				end
			endcase
		endfunction

		// Returns 0 when the byte is ignored by an idle scanner.
		function bit take_byte(logic [7:0] c, logic beg);
			step_t s;
			if (beg) begin
				esc = 1'b0;
				depth = 0;
				if (c != CH_BTICK) begin
					mode = MD_IDLE;
					len = 0;
					expect_result(ST_NONE, 0, 1'b0, 0);
				end else begin
					mode = MD_TEXT;
					len = 1;
				end
				return 1'b1;
			end
			if (mode == MD_IDLE)
				return 1'b0;
			if (c == CH_NUL) begin
				expect_result(ST_UNTERM, len, 1'b1, len);
				mode = MD_IDLE;
				return 1'b1;
			end
			if (len < LEN_CAP)
				len++;
			s = advance(c);
			if (s == STEP_MATCH) begin
				expect_result(ST_MATCH, len, 1'b1, len - 1);
				mode = MD_IDLE;
			end else if (s == STEP_OVER) begin
				expect_result(ST_OVER, len, 1'b1, len);
				mode = MD_IDLE;
				esc = 1'b0;
				depth = 0;
			end
			return 1'b1;
		endfunction

		function void check_result(status_t st, logic [15:0] tl, logic cb, logic [15:0] ce);
			result_t got;
			result_t want;
			got.status = st;
			got.token_length = tl;
			got.content_begin = cb;
			got.content_end = ce;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result: status %0d length %0d begin %0d end %0d",
						st, tl, cb, ce);
				return;
			end
			want = expected_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result mismatch: expected %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
						want.status, want.token_length, want.content_begin,
						want.content_end, got.status, got.token_length,
						got.content_begin, got.content_end);
			end
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

endpackage

/* bench/tb.sv */
// Top-level bench for template_literal_scanner_top: directed and random text streams
// with random gaps and stalls on both channels, checked by literal_tracker.
// Depends on tls_pkg and literal_track_pkg.
`timescale 1ns / 1ps

module tb;

	import tls_pkg::*;
	import literal_track_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 1250;
	localparam logic [7:0] BTICK_MARK = 8'h42;

	typedef struct packed {
		logic [7:0] ch;
		logic       beg;
	} text_item_t;

	logic        clk;
	logic        arst_n;
	logic        text_valid;
	logic        text_stall;
	logic [7:0]  ch;
	logic        begin_req;
	logic        result_valid;
	logic        result_stall;
	logic [1:0]  status;
	logic [15:0] token_length;
	logic        content_begin;
	logic [15:0] content_end;

	literal_tracker tracker;
	text_item_t     text_q [$];
	bit             calm;
	int unsigned    counted_items;

	template_literal_scanner_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.ch(ch),
		.begin_req(begin_req),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.token_length(token_length),
		.content_begin(content_begin),
		.content_end(content_end)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void put_byte(logic [7:0] c, logic beg = 1'b0);
		text_item_t it;
		it.ch = c;
		it.beg = beg;
		text_q.push_back(it);
	endfunction

	// Directed strings write an uppercase B where a backtick belongs.
	function automatic void put_str(string s, logic first_beg);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c == BTICK_MARK)
				c = CH_BTICK;
			put_byte(c, (i == 0) ? first_beg : 1'b0);
		end
	endfunction

	function automatic bit is_special(logic [7:0] c);
		return c inside {CH_NUL, CH_BTICK, CH_DOLLAR, CH_LBRACE, CH_RBRACE, CH_BSLASH,
			CH_SQUOTE};
	endfunction

	function automatic logic [7:0] plain_byte();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (is_special(c));
		return c;
	endfunction

	function automatic logic [7:0] special_byte();
		case ($urandom_range(0, 5))
			0: return CH_BTICK;
			1: return CH_DOLLAR;
			2: return CH_LBRACE;
			3: return CH_RBRACE;
			4: return CH_BSLASH;
			default: return CH_SQUOTE;
		endcase
	endfunction

	function automatic void gen_body(int level, int max_level);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 7))
				4: begin
					put_byte(CH_BSLASH);
					case ($urandom_range(0, 3))
						0: put_byte(CH_BSLASH);
						1: put_byte(CH_BTICK);
						2: put_byte(CH_DOLLAR);
						default: put_byte(plain_byte());
					endcase
				end
				5: begin
					put_byte(CH_DOLLAR);
					put_byte(plain_byte());
				end
				6, 7: begin
					if (level < max_level) begin
						put_byte(CH_DOLLAR);
						put_byte(CH_LBRACE);
						gen_expr(level + 1, max_level, 0);
						put_byte(CH_RBRACE);
					end else begin
						put_byte(plain_byte());
					end
				end
				default: put_byte(plain_byte());
			endcase
		end
	endfunction

	function automatic void gen_expr(int level, int max_level, int braces);
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 7))
				0: begin
					if (braces < 3) begin
						put_byte(CH_LBRACE);
						gen_expr(level, max_level, braces + 1);
						put_byte(CH_RBRACE);
					end
				end
				1: begin
					put_byte(CH_SQUOTE);
					repeat ($urandom_range(0, 3)) begin
						case ($urandom_range(0, 3))
							0: begin
								put_byte(CH_BSLASH);
								put_byte($urandom_range(0, 1) ? CH_SQUOTE : CH_BSLASH);
							end
							1: put_byte(special_byte() == CH_SQUOTE ? CH_BTICK : CH_DOLLAR);
							2: begin
								put_byte(CH_BSLASH);
								put_byte($urandom_range(0, 1) ? plain_byte() : CH_BTICK);
							end
							default: put_byte(plain_byte());
						endcase
					end
					put_byte(CH_SQUOTE);
				end
				2: begin
					put_byte(CH_BTICK);
					gen_body(level, max_level);
					put_byte(CH_BTICK);
				end
				3: put_byte($urandom_range(0, 1) ? CH_BSLASH : CH_DOLLAR);
				default: put_byte(plain_byte());
			endcase
		end
	endfunction

	function automatic void gen_deep(int levels);
		put_byte(CH_BTICK, 1'b1);
		repeat (levels) begin
			put_byte(CH_DOLLAR);
			put_byte(CH_LBRACE);
			put_byte(CH_BTICK);
		end
		repeat (levels) begin
			put_byte(CH_BTICK);
			put_byte(CH_RBRACE);
		end
		put_byte(CH_BTICK);
	endfunction

	function automatic void gen_sequence();
		int start;
		int cut;
		int pick;
		start = text_q.size();
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			put_byte(CH_BTICK, 1'b1);
			gen_body(0, $urandom_range(1, 4));
			put_byte(CH_BTICK);
			case ($urandom_range(0, 9))
				0, 1: begin
					cut = $urandom_range(start + 1, text_q.size() - 1);
					while (text_q.size() > cut)
						void'(text_q.pop_back());
					put_byte(CH_NUL);
				end
				2: begin
					cut = $urandom_range(start + 1, text_q.size() - 1);
					while (text_q.size() > cut)
						void'(text_q.pop_back());
				end
				3: begin
					cut = $urandom_range(start + 1, text_q.size() - 1);
					text_q[cut].ch = 8'($urandom_range(1, 255));
				end
				default: ;
			endcase
		end else if (pick < 70) begin
			gen_deep($urandom_range(6, 10));
		end else if (pick < 80) begin
			put_byte(8'($urandom_range(0, 255)), 1'b1);
		end else if (pick < 88) begin
			repeat ($urandom_range(1, 4))
				put_byte(8'($urandom_range(0, 255)));
		end else begin
			put_byte(CH_BTICK, 1'b1);
			repeat ($urandom_range(1, 12))
				put_byte($urandom_range(0, 1) ? special_byte() : 8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1))
				put_byte(CH_NUL);
		end
	endfunction

	task automatic send(text_item_t it);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 6);
		@(negedge clk);
		if (gap > 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		text_valid <= 1'b1;
		ch <= it.ch;
		begin_req <= it.beg;
		do
			@(posedge clk);
		while (text_stall);
		if (tracker.take_byte(it.ch, it.beg))
			counted_items++;
	endtask

	task automatic drain();
		while (text_q.size() != 0)
			send(text_q.pop_front());
	endtask

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = calm ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				result_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			result_stall <= 1'b0;
			do
				@(posedge clk);
			while (!result_valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			tracker.check_result(status_t'(status), token_length, content_begin, content_end);
	end

	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_valid && !text_stall) || (result_valid && !result_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("template_literal_scanner_top verification failed");
		$finish;
	end

	initial begin
		tracker = new();
		arst_n = 1'b0;
		text_valid = 1'b0;
		ch = 8'h00;
		begin_req = 1'b0;
		result_stall = 1'b0;
		calm = 1'b0;
		counted_items = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		put_str("BabB", 1'b1);
		put_byte(CH_NUL, 1'b1);
		put_byte(8'hFF, 1'b1);
		put_str("zz", 1'b0);
		put_str("Ba\\Bb\\$c\\\\\\d$e${1}$B", 1'b1);
		put_str("B${'\\'B{'}B", 1'b1);
		put_str("B${{B$x\\BB}}B", 1'b1);
		put_str("B${B${q}B}B", 1'b1);
		put_str("Babc", 1'b1);
		put_str("BdB", 1'b1);
		put_str("Bab", 1'b1);
		put_byte(CH_NUL);
		put_byte(CH_BTICK, 1'b1);
		repeat (NEST_DEPTH) put_str("${B", 1'b0);
		put_str("${", 1'b0);
		drain();

		counted_items = 0;
		while (counted_items < RANDOM_ITEMS) begin
			calm = ($urandom_range(0, 9) == 0);
			gen_sequence();
			drain();
		end
		calm = 1'b0;

		@(negedge clk);
		text_valid <= 1'b0;
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (tracker.pending() != 0)
			$display("%0d expected results never arrived", tracker.pending());
		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("template_literal_scanner_top verification clean");
		else
			$display("template_literal_scanner_top verification failed");
		$finish;
	end

endmodule
